// ===== sv/arlp_pkg.sv =====
// Shared types for the adjacent range link point block.
`default_nettype none

package arlp_pkg;

	localparam int CHIP_W  = 8;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 7;
	localparam int COORD_W = 7;
	// Signed working width for bounds: start + count - 1 spans -1..189.
	localparam int BOUND_W = 9;

	typedef struct packed {
		logic [CHIP_W-1:0]  first_chip;
		logic [POS_W-1:0]   first_row;
		logic [POS_W-1:0]   first_col;
		logic [COUNT_W-1:0] first_height;
		logic [COUNT_W-1:0] first_width;
		logic [CHIP_W-1:0]  second_chip;
		logic [POS_W-1:0]   second_row;
		logic [POS_W-1:0]   second_col;
		logic [COUNT_W-1:0] second_height;
		logic [COUNT_W-1:0] second_width;
	} arlp_item_t;

	typedef struct packed {
		logic               connected;
		logic [COORD_W-1:0] near_row;
		logic [COORD_W-1:0] near_col;
		logic [COORD_W-1:0] far_row;
		logic [COORD_W-1:0] far_col;
		logic [CHIP_W-1:0]  link_chip;
		logic               last;
	} arlp_result_t;

endpackage

`default_nettype wire

// ===== sv/adjacent_rect_link_points_top.sv =====
// Top level: input register, link point logic, result register with one-deep hold.
// The first result passes the input register, then the result register; a second
// result follows in the next cycle.
// Throughput: one transaction per cycle for single results; with two results each,
// the second waits in the hold and the single result port sets the rate.
// busy rises only while a second result waits and another transaction is held.
// Reset (arst_n low) empties all stages at once; no results follow it.
`default_nettype none

module adjacent_rect_link_points_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [arlp_pkg::CHIP_W-1:0]  first_chip,
	input  wire logic [arlp_pkg::POS_W-1:0]   first_row,
	input  wire logic [arlp_pkg::POS_W-1:0]   first_col,
	input  wire logic [arlp_pkg::COUNT_W-1:0] first_height,
	input  wire logic [arlp_pkg::COUNT_W-1:0] first_width,
	input  wire logic [arlp_pkg::CHIP_W-1:0]  second_chip,
	input  wire logic [arlp_pkg::POS_W-1:0]   second_row,
	input  wire logic [arlp_pkg::POS_W-1:0]   second_col,
	input  wire logic [arlp_pkg::COUNT_W-1:0] second_height,
	input  wire logic [arlp_pkg::COUNT_W-1:0] second_width,
	output logic                              result_valid,
	output logic                              connected,
	output logic [arlp_pkg::COORD_W-1:0]      near_row,
	output logic [arlp_pkg::COORD_W-1:0]      near_col,
	output logic [arlp_pkg::COORD_W-1:0]      far_row,
	output logic [arlp_pkg::COORD_W-1:0]      far_col,
	output logic [arlp_pkg::CHIP_W-1:0]       link_chip,
	output logic                              last
);
	import arlp_pkg::*;

	arlp_item_t   item_s1;
	logic         valid_s1;
	arlp_result_t res_first, res_second, out_q, pend_q;
	logic         two, out_valid_q, pend_valid_q;
	logic         accept, advance;

	// s1 moves on unless a held second result owns the output next cycle
	assign advance = !pend_valid_q;
	assign busy    = valid_s1 && pend_valid_q;
	assign accept  = start && !busy;

	arlp_link u_link (
		.item       (item_s1),
		.res_first  (res_first),
		.res_second (res_second),
		.two        (two)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= valid_s1;
				pend_valid_q <= valid_s1 && two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{first_chip:    first_chip,
			             first_row:     first_row,
			             first_col:     first_col,
			             first_height:  first_height,
			             first_width:   first_width,
			             second_chip:   second_chip,
			             second_row:    second_row,
			             second_col:    second_col,
			             second_height: second_height,
			             second_width:  second_width};
		end
		if (pend_valid_q) begin
			out_q <= pend_q;
		end else begin
			out_q  <= res_first;
			pend_q <= res_second;
		end
	end

	assign result_valid = out_valid_q;
	assign connected    = out_q.connected;
	assign near_row     = out_q.near_row;
	assign near_col     = out_q.near_col;
	assign far_row      = out_q.far_row;
	assign far_col      = out_q.far_col;
	assign link_chip    = out_q.link_chip;
	assign last         = out_q.last;

endmodule

`default_nettype wire

// ===== sv/arlp_link.sv =====
// Abutment test and link point selection for one pair of core ranges.
`default_nettype none

module arlp_link (
	input  arlp_pkg::arlp_item_t   item,
	output arlp_pkg::arlp_result_t res_first,
	output arlp_pkg::arlp_result_t res_second,
	output logic                   two
);
	import arlp_pkg::*;

	logic signed [BOUND_W-1:0] top1, left1, bot1, right1;
	logic signed [BOUND_W-1:0] top2, left2, bot2, right2;
	logic signed [BOUND_W-1:0] nfix, ffix, lo, hi;
	logic c_below, c_above, c_right, c_left;
	logic horiz, abut, overlap, connected;
	arlp_result_t none_res, pair_lo, pair_hi;

	always_comb begin
		top1   = $signed({3'b000, item.first_row});
		left1  = $signed({3'b000, item.first_col});
		top2   = $signed({3'b000, item.second_row});
		left2  = $signed({3'b000, item.second_col});
		bot1   = top1 + $signed({2'b00, item.first_height}) - 9'sd1;
		right1 = left1 + $signed({2'b00, item.first_width}) - 9'sd1;
		bot2   = top2 + $signed({2'b00, item.second_height}) - 9'sd1;
		right2 = left2 + $signed({2'b00, item.second_width}) - 9'sd1;

		c_below = (top1 - 9'sd1) == bot2;
		c_above = (top2 - 9'sd1) == bot1;
		c_right = (left1 - 9'sd1) == right2;
		c_left  = (left2 - 9'sd1) == right1;

		abut  = c_below || c_above || c_right || c_left;
		horiz = c_below || c_above;

		// first matching side wins
		if (c_below) begin
			nfix = top1;
			ffix = bot2;
		end else if (c_above) begin
			nfix = bot1;
			ffix = top2;
		end else if (c_right) begin
			nfix = left1;
			ffix = right2;
		end else begin
			nfix = right1;
			ffix = left2;
		end

		if (horiz) begin
			overlap = !(left1 > right2 || left2 > right1);
			lo      = (left1 > left2) ? left1 : left2;
			hi      = (right1 < right2) ? right1 : right2;
		end else begin
			overlap = !(bot1 < top2 || bot2 < top1);
			lo      = (top1 > top2) ? top1 : top2;
			hi      = (bot1 < bot2) ? bot1 : bot2;
		end

		connected = (item.first_chip == item.second_chip) && abut && overlap;
		two       = connected && (lo != hi);

		none_res      = '0;
		none_res.last = 1'b1;

		pair_lo.connected = 1'b1;
		pair_lo.link_chip = item.first_chip;
		pair_lo.last      = !two;
		pair_hi.connected = 1'b1;
		pair_hi.link_chip = item.first_chip;
		pair_hi.last      = 1'b1;
		if (horiz) begin
			pair_lo.near_row = nfix[COORD_W-1:0];
			pair_lo.near_col = lo[COORD_W-1:0];
			pair_lo.far_row  = ffix[COORD_W-1:0];
			pair_lo.far_col  = lo[COORD_W-1:0];
			pair_hi.near_row = nfix[COORD_W-1:0];
			pair_hi.near_col = hi[COORD_W-1:0];
			pair_hi.far_row  = ffix[COORD_W-1:0];
			pair_hi.far_col  = hi[COORD_W-1:0];
		end else begin
			pair_lo.near_row = lo[COORD_W-1:0];
			pair_lo.near_col = nfix[COORD_W-1:0];
			pair_lo.far_row  = lo[COORD_W-1:0];
			pair_lo.far_col  = ffix[COORD_W-1:0];
			pair_hi.near_row = hi[COORD_W-1:0];
			pair_hi.near_col = nfix[COORD_W-1:0];
			pair_hi.far_row  = hi[COORD_W-1:0];
			pair_hi.far_col  = ffix[COORD_W-1:0];
		end

		res_first  = connected ? pair_lo : none_res;
		res_second = pair_hi;
	end

endmodule

`default_nettype wire

// ===== sv/arlp_checker.sv =====
// Port-level checks for the link point block, bound to its top level.
`default_nettype none

module arlp_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         busy,
	input wire logic                         result_valid,
	input wire logic                         connected,
	input wire logic [arlp_pkg::COORD_W-1:0] near_row,
	input wire logic [arlp_pkg::COORD_W-1:0] near_col,
	input wire logic [arlp_pkg::COORD_W-1:0] far_row,
	input wire logic [arlp_pkg::COORD_W-1:0] far_col,
	input wire logic [arlp_pkg::CHIP_W-1:0]  link_chip,
	input wire logic                         last
);
	import arlp_pkg::*;

	// a first of two results is followed at once by the closing one
	a_pair_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid && last)
		else $error("second result of a pair did not follow");

	a_open_is_linked: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> connected)
		else $error("non-final result without a link");

	a_none_is_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !connected |-> last && link_chip == '0 && near_row == '0
			&& near_col == '0 && far_row == '0 && far_col == '0)
		else $error("not-connected result carries data");

	// busy falls again in the next cycle: the held second result drains right away
	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

endmodule

bind adjacent_rect_link_points_top arlp_checker u_arlp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.busy         (busy),
	.result_valid (result_valid),
	.connected    (connected),
	.near_row     (near_row),
	.near_col     (near_col),
	.far_row      (far_row),
	.far_col      (far_col),
	.link_chip    (link_chip),
	.last         (last)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for adjacent_rect_link_points_top: random and directed ranges, link predictor.
`timescale 1ns / 100ps

module tb_top;
	import arlp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 10;
	localparam int RANDOM_ITEMS = 630;
	localparam int CALM_ITEMS = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	arlp_item_t cur = '0;

	logic busy;
	logic result_valid;
	logic connected;
	logic [COORD_W-1:0] near_row;
	logic [COORD_W-1:0] near_col;
	logic [COORD_W-1:0] far_row;
	logic [COORD_W-1:0] far_col;
	logic [CHIP_W-1:0] link_chip;
	logic last;

	arlp_item_t pending_items[$];
	arlp_result_t expected_links[$];
	int hold_at[$];

	int total_items = 0;
	int sent = 0;
	int accepted = 0;
	int cycles = 0;
	int mismatches = 0;
	int idle_left = 0;
	int calm_from = 0;
	bit taken = 1'b0;
	arlp_result_t got;
	arlp_result_t want;

	adjacent_rect_link_points_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.first_chip(cur.first_chip),
		.first_row(cur.first_row),
		.first_col(cur.first_col),
		.first_height(cur.first_height),
		.first_width(cur.first_width),
		.second_chip(cur.second_chip),
		.second_row(cur.second_row),
		.second_col(cur.second_col),
		.second_height(cur.second_height),
		.second_width(cur.second_width),
		.result_valid(result_valid),
		.connected(connected),
		.near_row(near_row),
		.near_col(near_col),
		.far_row(far_row),
		.far_col(far_col),
		.link_chip(link_chip),
		.last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void queue_item(arlp_item_t it);
		pending_items = {pending_items, it};
	endfunction

	function automatic void queue_expect(arlp_result_t res);
		expected_links = {expected_links, res};
	endfunction

	function automatic void queue_hold(int at);
		hold_at = {hold_at, at};
	endfunction

	function automatic arlp_item_t make_ranges(int c1, int r1, int k1, int h1, int w1,
			int c2, int r2, int k2, int h2, int w2);
		arlp_item_t it;
		it.first_chip = CHIP_W'(c1);
		it.first_row = POS_W'(r1);
		it.first_col = POS_W'(k1);
		it.first_height = COUNT_W'(h1);
		it.first_width = COUNT_W'(w1);
		it.second_chip = CHIP_W'(c2);
		it.second_row = POS_W'(r2);
		it.second_col = POS_W'(k2);
		it.second_height = COUNT_W'(h2);
		it.second_width = COUNT_W'(w2);
		return it;
	endfunction

	// dir: 0 range one below, 1 above, 2 right of, 3 left of range two
	function automatic arlp_item_t make_link_pair(int dir);
		int lo_start, lo_len, hi_start, hi_len;
		int a1, m1, a2, m2, s1, n1, s2, n2, chip;
		lo_len = $urandom_range(1, 12);
		lo_start = $urandom_range(0, 62 - lo_len);
		hi_start = lo_start + lo_len;
		hi_len = $urandom_range(1, 64 - hi_start);
		s1 = $urandom_range(0, 63);
		n1 = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 16);
		s2 = $urandom_range(s1 > 10 ? s1 - 10 : 0, (s1 + n1 > 63) ? 63 : s1 + n1);
		n2 = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 16);
		chip = $urandom_range(0, 255);
		if (dir == 1 || dir == 3) begin
			a1 = lo_start; m1 = lo_len; a2 = hi_start; m2 = hi_len;
		end else begin
			a1 = hi_start; m1 = hi_len; a2 = lo_start; m2 = lo_len;
		end
		if (dir < 2)
			return make_ranges(chip, a1, s1, m1, n1, chip, a2, s2, m2, n2);
		return make_ranges(chip, s1, a1, n1, m1, chip, s2, a2, n2, m2);
	endfunction

	function automatic void predict_links(arlp_item_t it);
		int t1, l1, b1, r1, t2, l2, b2, r2, nfix, ffix, lo, hi;
		bit horiz, abut;
		arlp_result_t res;
		t1 = int'(it.first_row);
		l1 = int'(it.first_col);
		b1 = t1 + int'(it.first_height) - 1;
		r1 = l1 + int'(it.first_width) - 1;
		t2 = int'(it.second_row);
		l2 = int'(it.second_col);
		b2 = t2 + int'(it.second_height) - 1;
		r2 = l2 + int'(it.second_width) - 1;
		abut = 1'b1;
		horiz = 1'b0;
		nfix = 0;
		ffix = 0;
		lo = 0;
		hi = 0;
		// only the first matching edge test counts
		if (t1 - 1 == b2) begin
			horiz = 1'b1; nfix = t1; ffix = b2;
		end else if (t2 - 1 == b1) begin
			horiz = 1'b1; nfix = b1; ffix = t2;
		end else if (l1 - 1 == r2) begin
			nfix = l1; ffix = r2;
		end else if (l2 - 1 == r1) begin
			nfix = r1; ffix = l2;
		end else begin
			abut = 1'b0;
		end
		if (abut && horiz) begin
			if (l1 > r2 || l2 > r1)
				abut = 1'b0;
			lo = (l1 > l2) ? l1 : l2;
			hi = (r1 < r2) ? r1 : r2;
		end else if (abut) begin
			if (b1 < t2 || b2 < t1)
				abut = 1'b0;
			lo = (t1 > t2) ? t1 : t2;
			hi = (b1 < b2) ? b1 : b2;
		end
		res = '0;
		if (it.first_chip != it.second_chip || !abut) begin
			res.last = 1'b1;
			queue_expect(res);
		end else begin
			res.connected = 1'b1;
			res.link_chip = it.first_chip;
			for (int e = 0; e < 2; e++) begin
				if (e == 0 || lo != hi) begin
					if (horiz) begin
						res.near_row = COORD_W'(nfix);
						res.near_col = COORD_W'(e == 0 ? lo : hi);
						res.far_row = COORD_W'(ffix);
						res.far_col = COORD_W'(e == 0 ? lo : hi);
					end else begin
						res.near_row = COORD_W'(e == 0 ? lo : hi);
						res.near_col = COORD_W'(nfix);
						res.far_row = COORD_W'(e == 0 ? lo : hi);
						res.far_col = COORD_W'(ffix);
					end
					res.last = (e == 1 || lo == hi);
					queue_expect(res);
				end
			end
		end
	endfunction

	// Driver: hold a raised start until the transaction is taken
	always @(negedge clk) begin
		if (arst_n && !(start && !taken)) begin
			taken = 1'b0;
			if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (hold_at.size() != 0 && sent == hold_at[0]
					&& expected_links.size() != 0) begin
				start <= 1'b0;
			end else if (pending_items.size() != 0) begin
				if (hold_at.size() != 0 && sent == hold_at[0])
					void'(hold_at.pop_front());
				if (sent < calm_from && ((sent / 40) % 3) != 2
						&& $urandom_range(0, 5) == 0) begin
					idle_left = $urandom_range(1, 19) - 1;
					start <= 1'b0;
				end else begin
					cur <= pending_items.pop_front();
					start <= 1'b1;
					sent++;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check results first, then predict for a newly taken transaction
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end else begin
				if (result_valid) begin
					got = {connected, near_row, near_col, far_row, far_col, link_chip, last};
					if (expected_links.size() == 0) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"unexpected result: c=%0d nr=%0d nc=%0d fr=%0d",
								" fc=%0d chip=%0d last=%0d"},
								got.connected, got.near_row, got.near_col, got.far_row,
								got.far_col, got.link_chip, got.last);
					end else begin
						want = expected_links.pop_front();
						if (got !== want) begin
							mismatches++;
							if (mismatches <= 10) begin
								$display({"mismatch want: c=%0d nr=%0d nc=%0d fr=%0d",
									" fc=%0d chip=%0d last=%0d"},
									want.connected, want.near_row, want.near_col,
									want.far_row, want.far_col, want.link_chip, want.last);
								$display({"          got: c=%0d nr=%0d nc=%0d fr=%0d",
									" fc=%0d chip=%0d last=%0d"},
									got.connected, got.near_row, got.near_col,
									got.far_row, got.far_col, got.link_chip, got.last);
							end
						end
					end
				end
				if (start && !busy) begin
					predict_links(cur);
					accepted++;
					taken = 1'b1;
				end
			end
		end
	end

	initial begin
		arlp_item_t it;
		int pick, v;
		// chips differ, ranges otherwise abut
		queue_item(make_ranges(3, 10, 4, 3, 5, 4, 7, 4, 3, 5));
		// below, above, right of, left of: wide and single-core overlaps
		queue_item(make_ranges(7, 10, 4, 3, 5, 7, 7, 2, 3, 6));
		queue_item(make_ranges(7, 10, 4, 3, 5, 7, 7, 8, 3, 6));
		queue_item(make_ranges(9, 20, 0, 4, 64, 9, 24, 10, 2, 3));
		queue_item(make_ranges(9, 20, 5, 4, 1, 9, 24, 0, 2, 64));
		queue_item(make_ranges(1, 5, 30, 10, 2, 1, 8, 20, 20, 10));
		queue_item(make_ranges(1, 5, 30, 10, 2, 1, 14, 20, 5, 10));
		queue_item(make_ranges(2, 0, 0, 64, 32, 2, 0, 32, 64, 32));
		queue_item(make_ranges(2, 63, 10, 1, 5, 2, 63, 15, 1, 1));
		// first matching edge has no overlap, and the later matching edge has none either
		queue_item(make_ranges(5, 10, 4, 3, 5, 5, 7, 9, 3, 6));
		// far apart, then overlapping
		queue_item(make_ranges(5, 0, 0, 2, 2, 5, 40, 40, 3, 3));
		queue_item(make_ranges(5, 10, 10, 5, 5, 5, 12, 12, 5, 5));
		// field extremes
		queue_item(make_ranges(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_item(make_ranges(255, 63, 63, 127, 127, 255, 63, 63, 127, 127));
		// zero counts put the far bound at start - 1
		queue_item(make_ranges(6, 5, 0, 3, 10, 6, 5, 3, 0, 4));
		queue_item(make_ranges(6, 3, 0, 4, 0, 6, 5, 0, 4, 2));
		// oversized counts wrap emitted coordinates
		queue_item(make_ranges(4, 50, 0, 100, 10, 4, 60, 10, 120, 5));
		queue_item(make_ranges(8, 0, 60, 1, 100, 8, 1, 0, 5, 127));
		queue_item(make_ranges(0, 1, 1, 1, 1, 255, 2, 1, 1, 1));
		queue_item(make_ranges('hAA, 'h2A, 'h15, 'h55, 'h2A,
			'h55, 'h15, 'h2A, 'h2A, 'h55));
		queue_hold(pending_items.size());

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 78) begin
				it = make_link_pair($urandom_range(0, 3));
				if (pick >= 70) begin
					v = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127);
					case ($urandom_range(0, 3))
						0: it.first_height = COUNT_W'(v);
						1: it.first_width = COUNT_W'(v);
						2: it.second_height = COUNT_W'(v);
						default: it.second_width = COUNT_W'(v);
					endcase
				end
			end else begin
				it = make_ranges($urandom_range(0, 255), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 255), $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 127), $urandom_range(0, 127));
				if (pick < 90)
					it.second_chip = it.first_chip;
			end
			queue_item(it);
			if (i == 230 || i == 460)
				queue_hold(pending_items.size());
		end
		total_items = pending_items.size();
		calm_from = total_items - CALM_ITEMS;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (accepted != total_items || expected_links.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_links.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
